/* rtl/cwms_pkg.sv */
// shared constants for the channel weighted map sum unit
`timescale 1ns / 1ps
package cwms_pkg;

  localparam int MAX_POSITIONS_DEF = 4096;
  localparam int MAX_CHANNELS_DEF  = 1024;
  localparam int FEATURE_WIDTH_DEF = 16;

  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 42;
  localparam int CH_CNT_W   = 11;
  localparam int POS_CNT_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 2'd1;

  localparam logic [CH_CNT_W-1:0]  CH_CNT_RST  = 11'd512;
  localparam logic [POS_CNT_W-1:0] POS_CNT_RST = 13'd196;

endpackage

/* rtl/channel_weighted_map_sum_unit.sv */
// channel weighted map sum: per-position multiply-accumulate over channels
`timescale 1ns / 1ps
// path: a finishing transfer passes stage 1, stage 2 and the output register
// throughput: one input transfer per cycle unless the result side stalls, set by the
//   read-add-write loop on the accumulator ram (read at transfer, multiply, add, write back)
// reset: clears channel and position indices, pipeline and output valid, and loads
//   the counts 512 and 196; the accumulator ram is not cleared, channel 0 overwrites it
module channel_weighted_map_sum_unit #(
  parameter int MAX_POSITIONS = cwms_pkg::MAX_POSITIONS_DEF,
  parameter int MAX_CHANNELS  = cwms_pkg::MAX_CHANNELS_DEF,
  parameter int FEATURE_WIDTH = cwms_pkg::FEATURE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [cwms_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cwms_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [FEATURE_WIDTH-1:0]        in_feature_value,
  input  logic signed [cwms_pkg::WEIGHT_W-1:0]   in_channel_weight,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cwms_pkg::SUM_W-1:0]      out_weighted_sum,
  output logic                                   out_last_of_map
);

  localparam int SW  = cwms_pkg::SUM_W;
  localparam int WW  = cwms_pkg::WEIGHT_W;
  localparam int PRW = FEATURE_WIDTH + WW;
  localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // compare widths hold both the count register and the clamp limit
  localparam int CMW = ((cwms_pkg::CH_CNT_W > CW) ? cwms_pkg::CH_CNT_W : CW) + 1;
  localparam int PMW = ((cwms_pkg::POS_CNT_W > PW) ? cwms_pkg::POS_CNT_W : PW) + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [cwms_pkg::CH_CNT_W-1:0]  ch_cnt_r;
  logic [cwms_pkg::POS_CNT_W-1:0] pos_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r  <= cwms_pkg::CH_CNT_RST;
      pos_cnt_r <= cwms_pkg::POS_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cwms_pkg::REG_CHANNEL_COUNT:  ch_cnt_r  <= cfg_wdata[cwms_pkg::CH_CNT_W-1:0];
        cwms_pkg::REG_POSITION_COUNT: pos_cnt_r <= cfg_wdata[cwms_pkg::POS_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts minus one: zero acts as one, too large acts as the maximum
  logic [CMW-1:0] ch_cnt_ext, chans_m1;
  logic [PMW-1:0] pos_cnt_ext, poss_m1;

  always_comb begin
    ch_cnt_ext  = CMW'(ch_cnt_r);
    pos_cnt_ext = PMW'(pos_cnt_r);
    if (ch_cnt_ext == '0)
      chans_m1 = '0;
    else if (ch_cnt_ext > CMW'(MAX_CHANNELS))
      chans_m1 = CMW'(MAX_CHANNELS - 1);
    else
      chans_m1 = ch_cnt_ext - 1'b1;
    if (pos_cnt_ext == '0)
      poss_m1 = '0;
    else if (pos_cnt_ext > PMW'(MAX_POSITIONS))
      poss_m1 = PMW'(MAX_POSITIONS - 1);
    else
      poss_m1 = pos_cnt_ext - 1'b1;
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic s2_emit_r;
  logic out_free, s2_go, s1_go, in_xfer;

  assign out_free = !out_v_r || out_ready;
  // items that finish no result leave stage 2 without waiting for the output
  assign s2_go    = s2_v_r && (!s2_emit_r || out_free);
  assign s1_go    = s1_v_r && (!s2_v_r || s2_go);
  assign in_ready = !s1_v_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // stage 0: index tracking and accumulator read
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos_idx_r, pos_idx_nxt;
  logic [CW-1:0] ch_idx_r, ch_idx_nxt;
  logic          last_pos, last_chan, first_chan;

  always_comb begin
    // an index at or past the last legal value counts as the last one
    last_pos   = PMW'(pos_idx_r) >= poss_m1;
    last_chan  = CMW'(ch_idx_r) >= chans_m1;
    first_chan = (ch_idx_r == '0);
    if (last_pos) begin
      pos_idx_nxt = '0;
      ch_idx_nxt  = last_chan ? '0 : ch_idx_r + 1'b1;
    end else begin
      pos_idx_nxt = pos_idx_r + 1'b1;
      ch_idx_nxt  = ch_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_idx_r <= '0;
      ch_idx_r  <= '0;
    end else if (in_xfer) begin
      pos_idx_r <= pos_idx_nxt;
      ch_idx_r  <= ch_idx_nxt;
    end
  end

  // stage 2 write-back, used by the ram and by forwarding
  logic [PW-1:0] s2_slot_r;
  logic [SW-1:0] s2_sum;
  logic          wr_en;
  assign wr_en = s2_go;

  // accumulator ram, one entry per position, read-before-write
  logic [SW-1:0] acc_mem [MAX_POSITIONS];
  logic [SW-1:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (wr_en)
      acc_mem[s2_slot_r] <= s2_sum;
    if (in_xfer)
      mem_q_r <= acc_mem[pos_idx_r];
  end

  // ---------------------------------------------------------------------------
  // stage 1: operands held, read data arrives, multiply
  // ---------------------------------------------------------------------------
  logic [PW-1:0]                s1_slot_r;
  logic                         s1_first_r, s1_emit_r, s1_last_r;
  logic signed [FEATURE_WIDTH-1:0] s1_feat_r;
  logic signed [WW-1:0]         s1_wt_r;
  // a write to the same slot after the read was issued replaces the read data
  logic                         s1_fwd_v_r;
  logic [SW-1:0]                s1_fwd_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_v_r <= 1'b0;
    else if (in_xfer)
      s1_v_r <= 1'b1;
    else if (s1_go)
      s1_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_slot_r  <= pos_idx_r;
      s1_first_r <= first_chan;
      s1_emit_r  <= last_chan;
      s1_last_r  <= last_pos;
      s1_feat_r  <= in_feature_value;
      s1_wt_r    <= in_channel_weight;
      // ram reads old data when the same slot is written at this edge
      s1_fwd_v_r <= wr_en && (s2_slot_r == pos_idx_r);
      s1_fwd_d_r <= s2_sum;
    end else if (wr_en && (s2_slot_r == s1_slot_r)) begin
      s1_fwd_v_r <= 1'b1;
      s1_fwd_d_r <= s2_sum;
    end
  end

  logic signed [PRW-1:0]    mul;
  logic signed [PRW+SW-1:0] mul_ext;
  logic [SW-1:0]            s1_acc_sel;

  assign mul     = s1_feat_r * s1_wt_r;
  assign mul_ext = (PRW + SW)'(mul);

  always_comb begin
    if (wr_en && (s2_slot_r == s1_slot_r))
      s1_acc_sel = s2_sum;
    else if (s1_fwd_v_r)
      s1_acc_sel = s1_fwd_d_r;
    else
      s1_acc_sel = mem_q_r;
  end

  // ---------------------------------------------------------------------------
  // stage 2: add, write back, hand result to the output register
  // ---------------------------------------------------------------------------
  logic          s2_first_r, s2_last_r;
  logic [SW-1:0] s2_prod_r, s2_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s2_v_r <= 1'b0;
    else if (s1_go)
      s2_v_r <= 1'b1;
    else if (s2_go)
      s2_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_slot_r  <= s1_slot_r;
      s2_first_r <= s1_first_r;
      s2_emit_r  <= s1_emit_r;
      s2_last_r  <= s1_last_r;
      s2_prod_r  <= mul_ext[SW-1:0];
      s2_acc_r   <= s1_acc_sel;
    end
  end

  // channel 0 overwrites, later channels add; wraps modulo 2^42
  assign s2_sum = s2_first_r ? s2_prod_r : s2_acc_r + s2_prod_r;

  // output register
  logic [SW-1:0] out_sum_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_v_r <= 1'b0;
    else if (s2_go && s2_emit_r)
      out_v_r <= 1'b1;
    else if (out_ready)
      out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit_r) begin
      out_sum_r  <= s2_sum;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_weighted_sum = out_sum_r;
  assign out_last_of_map  = out_last_r;

endmodule

/* rtl/cwms_checker.sv */
// port-level checks for the channel weighted map sum unit, with bind
`timescale 1ns / 1ps
module cwms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cwms_pkg::SUM_W-1:0]    out_weighted_sum,
  input logic                          out_last_of_map
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weighted_sum)
      && $stable(out_last_of_map))
    else $error("result changed while stalled");

  // with the output register free the pipe must take a transfer
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset leaves the pipe empty and ready
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind channel_weighted_map_sum_unit cwms_checker u_cwms_checker (.*);

/* tb/testbench.sv */
// self-checking testbench for the channel weighted map sum unit
`timescale 1ns / 1ps
module testbench;
  import cwms_pkg::*;

  typedef logic signed [FEATURE_WIDTH_DEF-1:0] feat_t;
  typedef logic signed [WEIGHT_W-1:0]          wgt_t;
  typedef logic signed [SUM_W-1:0]             sum_t;

  // one position's finished sum as it leaves the block
  typedef struct packed {
    sum_t sum;
    logic last;
  } map_result_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  // one line of the directed table: a register write or an input transfer,
  // optionally with its result spelled out by hand
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    feat_t                 feat;
    wgt_t                  wgt;
    bit                    typed;
    map_result_t           result;
  } stim_row_t;

  // who idles: slow sink first, then slow source, then both at full rate
  typedef enum logic [1:0] {SLOW_SINK, SLOW_SOURCE, FULL_RATE} pace_t;

  localparam int RANDOM_ITEMS    = 250;
  localparam int STALL_POSITIONS = 64;
  localparam int DRAIN_CYCLES    = 8;     // a result passes stage 1, stage 2 and the output register
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 400;   // long sink stall to back up the pipeline
  localparam int WATCHDOG_LIMIT  = 3000;  // well above the longest stall of a good run
  localparam int REPORT_LIMIT    = 10;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  feat_t                 in_feature_value  = '0;
  wgt_t                  in_channel_weight = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  sum_t                  out_weighted_sum;
  logic                  out_last_of_map;

  channel_weighted_map_sum_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_feature_value  (in_feature_value),
    .in_channel_weight (in_channel_weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_weighted_sum  (out_weighted_sum),
    .out_last_of_map   (out_last_of_map)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mirror of the block: per-position sums, walk indices and the two counts
  // ---------------------------------------------------------------------------
  sum_t                                   acc_mirror [MAX_POSITIONS_DEF];
  logic [$clog2(MAX_CHANNELS_DEF)-1:0]    chan_idx_mirror   = '0;
  logic [$clog2(MAX_POSITIONS_DEF)-1:0]   pos_idx_mirror    = '0;
  logic [CH_CNT_W-1:0]                    chan_count_mirror = CH_CNT_RST;
  logic [POS_CNT_W-1:0]                   pos_count_mirror  = POS_CNT_RST;

  map_result_t expected_sums [$];   // sums still owed by the block, oldest first
  int unsigned error_count   = 0;
  int unsigned random_items  = 0;
  int unsigned hold_requests = 0;
  pace_t       pace          = SLOW_SINK;
  wgt_t        chan_weight   = '0;

  // a count of zero means one, anything past the store size means the store size
  function automatic int unsigned effective_count(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic mirror_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHANNEL_COUNT:  chan_count_mirror = data[CH_CNT_W-1:0];
      REG_POSITION_COUNT: pos_count_mirror  = data;
      default: ;
    endcase
  endtask

  // one multiply-accumulate; a result comes out on the last channel only
  task automatic mirror_accumulate(input feat_t f, input wgt_t w,
                                   output bit emits, output map_result_t res);
    int unsigned chans;
    int unsigned poss;
    bit          last_pos;
    bit          last_chan;
    sum_t        prod;
    chans     = effective_count(chan_count_mirror, MAX_CHANNELS_DEF);
    poss      = effective_count(pos_count_mirror, MAX_POSITIONS_DEF);
    prod      = sum_t'(f) * sum_t'(w);
    // an index left past the end by a shrinking write counts as the last one
    last_pos  = pos_idx_mirror >= poss - 1;
    last_chan = chan_idx_mirror >= chans - 1;
    if (chan_idx_mirror == 0) begin
      acc_mirror[pos_idx_mirror] = prod;
    end else begin
      acc_mirror[pos_idx_mirror] = acc_mirror[pos_idx_mirror] + prod;
    end
    emits    = last_chan;
    res.sum  = acc_mirror[pos_idx_mirror];
    res.last = last_pos;
    if (last_pos) begin
      pos_idx_mirror  = '0;
      chan_idx_mirror = last_chan ? '0 : chan_idx_mirror + 1'b1;
    end else begin
      pos_idx_mirror = pos_idx_mirror + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one element and wait for its transfer; valid stays up afterwards
  // so a following call keeps the channel busy without a bubble
  task automatic send_item(input feat_t f, input wgt_t w, input bit typed,
                           input map_result_t typed_res);
    int unsigned gap_pct;
    bit          emits;
    map_result_t res;
    gap_pct = (pace == SLOW_SINK) ? 27 : (pace == SLOW_SOURCE) ? 49 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_feature_value  <= f;
    in_channel_weight <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer at this edge
    mirror_accumulate(f, w, emits, res);
    if (typed) res = typed_res;
    if (emits) expected_sums = {expected_sums, res};
  endtask

  // registers change only with the block drained; an element that produces
  // no result may still be in flight, so give it the latency on top
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_write(idx, data);
  endtask

  // mostly full-range values, with the corners mixed in often
  function automatic feat_t pick_value();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return feat_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_count(int unsigned small_hi, int unsigned mid_hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 88) return $urandom_range(small_hi, 1);
    return $urandom_range(mid_hi, small_hi + 1);
  endfunction

  // one element of a well-formed map: one weight per channel, now and then a
  // stray weight on a single element
  task automatic send_random_item();
    wgt_t w;
    if (pos_idx_mirror == 0) chan_weight = wgt_t'(pick_value());
    w = ($urandom_range(9) == 0) ? wgt_t'(pick_value()) : chan_weight;
    send_item(pick_value(), w, 1'b0, '0);
    random_items++;
  endtask

  // new map shape, a few whole samples, sometimes a sample cut short by a
  // shrinking write; growing is only done on a sample boundary so no
  // position is ever added to before channel 0 has written it
  task automatic run_phase();
    int unsigned chans;
    int unsigned poss;
    int unsigned sample_len;
    int unsigned cut;
    int unsigned shrink_ch;
    int unsigned shrink_pos;
    chans = pick_count(6, 16);
    poss  = pick_count(12, 48);
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(chans));
    write_reg(REG_POSITION_COUNT, CFG_DATA_W'(poss));
    sample_len = effective_count(chans, MAX_CHANNELS_DEF)
               * effective_count(poss, MAX_POSITIONS_DEF);
    repeat ($urandom_range(3, 1) * sample_len) send_random_item();
    if (sample_len > 1 && $urandom_range(4) == 0) begin
      cut = $urandom_range(sample_len - 1, 1);
      repeat (cut) send_random_item();
      shrink_ch  = $urandom_range(effective_count(chans, MAX_CHANNELS_DEF), 1);
      shrink_pos = $urandom_range(effective_count(poss, MAX_POSITIONS_DEF), 1);
      write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(shrink_ch));
      write_reg(REG_POSITION_COUNT, CFG_DATA_W'(shrink_pos));
      while (chan_idx_mirror != 0 || pos_idx_mirror != 0) send_random_item();
    end
  endtask

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_WRITE, reg_idx: idx, reg_data: data, feat: '0, wgt: '0,
          typed: 1'b0, result: '0};
    return r;
  endfunction

  function automatic stim_row_t item_row(feat_t f, wgt_t w);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_data: '0, feat: f, wgt: w,
          typed: 1'b0, result: '0};
    return r;
  endfunction

  function automatic stim_row_t known_row(feat_t f, wgt_t w, sum_t s, logic l);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_data: '0, feat: f, wgt: w,
          typed: 1'b1, result: '{sum: s, last: l}};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows [$];

    // one channel, one position: every element is its own finished map
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd1)};
    directed_rows = {directed_rows, reg_row(REG_POSITION_COUNT, 13'd1)};
    directed_rows = {directed_rows, known_row(16'sh8000, 16'sh8000, 42'sd1073741824, 1'b1)};
    directed_rows = {directed_rows, known_row(16'sh7fff, 16'sh7fff, 42'sd1073676289, 1'b1)};
    directed_rows = {directed_rows, known_row(16'sh8000, 16'sh7fff, -42'sd1073709056, 1'b1)};
    directed_rows = {directed_rows, known_row(16'sh7fff, 16'sh8000, -42'sd1073709056, 1'b1)};
    directed_rows = {directed_rows, known_row(16'sd0, -16'sd1, 42'sd0, 1'b1)};
    directed_rows = {directed_rows, known_row(-16'sd1, 16'sd1, -42'sd1, 1'b1)};
    // zero counts behave as one
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd0)};
    directed_rows = {directed_rows, reg_row(REG_POSITION_COUNT, 13'd0)};
    directed_rows = {directed_rows, known_row(16'sd256, 16'sh8000, -42'sd8388608, 1'b1)};
    // two channels of three positions
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd2)};
    directed_rows = {directed_rows, reg_row(REG_POSITION_COUNT, 13'd3)};
    directed_rows = {directed_rows, item_row(16'sd100, 16'sd16384)};
    directed_rows = {directed_rows, item_row(-16'sd200, 16'sd16384)};
    directed_rows = {directed_rows, item_row(16'sh7fff, 16'sd16384)};
    directed_rows = {directed_rows, item_row(16'sh8000, -16'sd16384)};
    directed_rows = {directed_rows, item_row(16'sd5, -16'sd16384)};
    directed_rows = {directed_rows, item_row(16'sh7fff, 16'sh8000)};
    // counts shrunk mid-sample: the walk sits past the new position end and on
    // the last channel, so the next element finishes the map at once
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd3)};
    directed_rows = {directed_rows, reg_row(REG_POSITION_COUNT, 13'd2)};
    directed_rows = {directed_rows, item_row(16'sd1000, 16'sd20000)};
    directed_rows = {directed_rows, item_row(-16'sd1000, 16'sd20000)};
    directed_rows = {directed_rows, item_row(16'sd300, -16'sd7)};
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd2)};
    directed_rows = {directed_rows, reg_row(REG_POSITION_COUNT, 13'd1)};
    directed_rows = {directed_rows, item_row(-16'sd4, 16'sd3)};
    directed_rows = {directed_rows, item_row(16'sd7, 16'sd7)};
    directed_rows = {directed_rows, item_row(-16'sd7, 16'sd9)};
    // four channels into one position, sum crossing zero
    directed_rows = {directed_rows, reg_row(REG_CHANNEL_COUNT, 13'd4)};
    directed_rows = {directed_rows, item_row(16'sh7fff, 16'sh7fff)};
    directed_rows = {directed_rows, item_row(16'sh8000, 16'sh7fff)};
    directed_rows = {directed_rows, item_row(16'sd12345, 16'sh8000)};
    directed_rows = {directed_rows, item_row(-16'sd1, -16'sd1)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i].feat, directed_rows[i].wgt, directed_rows[i].typed,
                  directed_rows[i].result);
      end
    end

    // random maps, pacing changes every third of the way
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 2 * RANDOM_ITEMS / 3) begin
        pace = FULL_RATE;
      end else if (random_items >= RANDOM_ITEMS / 3) begin
        pace = SLOW_SOURCE;
      end
      run_phase();
    end

    // deepest channel sum: all bits set in the register clamps to the
    // maximum, and corner values everywhere give the largest sum
    write_reg(REG_CHANNEL_COUNT, '1);
    write_reg(REG_POSITION_COUNT, 13'd1);
    repeat (MAX_CHANNELS_DEF) send_item(16'sh8000, 16'sh8000, 1'b0, '0);

    // single-channel map with a long sink stall while the source keeps pushing
    write_reg(REG_CHANNEL_COUNT, 13'd1);
    write_reg(REG_POSITION_COUNT, CFG_DATA_W'(STALL_POSITIONS));
    hold_requests++;
    repeat (STALL_POSITIONS) send_random_item();

    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: compare each transfer with the oldest owed sum, then pick
  // the next ready value
  // ---------------------------------------------------------------------------
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;

  always @(posedge clk) begin : result_check
    map_result_t want;
    int unsigned stall_pct;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("unexpected result: sum %0d last %0b", out_weighted_sum,
                     out_last_of_map);
          end
        end else begin
          want = expected_sums.pop_front();
          if (out_weighted_sum !== want.sum || out_last_of_map !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("mismatch: sum %0d last %0b, expected sum %0d last %0b",
                       out_weighted_sum, out_last_of_map, $signed(want.sum), want.last);
            end
          end
        end
      end
      // long stall counted here so the source side never waits on it
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (pace == SLOW_SINK) ? 49 : (pace == SLOW_SOURCE) ? 27 : 0;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
